// ===== rtl/ship_pkg.sv =====
// ----------------------------------------------------------------------------
// ship_pkg
// Shared types and constants of the signature-based RRIP replacement block.
// ----------------------------------------------------------------------------
package ship_pkg;

   localparam int RRPV_W      = 2;
   localparam int CTR_W       = 2;
   localparam int FUNC_W      = 1;
   localparam int SET_IN_W    = 11;
   localparam int WAY_IN_W    = 4;
   localparam int PC_W        = 64;
   localparam int VICTIM_W    = 4;
   localparam int SIG_SHIFT   = 4;
   localparam int CHUNK_W     = 12;
   localparam int CHUNKS      = (PC_W - SIG_SHIFT) / CHUNK_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 2;
   localparam int NUM_INSERT  = 4;

   localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
   localparam logic [RRPV_W-1:0] RRPV_HIT  = 2'd0;
   localparam logic [CTR_W-1:0]  CTR_MAX   = 2'd3;
   localparam logic [CTR_W-1:0]  CTR_MIN   = 2'd0;
   localparam logic [CTR_W-1:0]  CTR_RESET = 2'd1;

   localparam logic [FUNC_W-1:0] FUNC_VICTIM = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_INSERT_DEAD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSERT_MILD    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSERT_REGULAR = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSERT_HOT     = 2'd3;

   localparam logic [RRPV_W-1:0] INSERT_DEAD_RESET    = 2'd3;
   localparam logic [RRPV_W-1:0] INSERT_MILD_RESET    = 2'd1;
   localparam logic [RRPV_W-1:0] INSERT_REGULAR_RESET = 2'd2;
   localparam logic [RRPV_W-1:0] INSERT_HOT_RESET     = 2'd0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_EXEC
   } ship_state_type;

   typedef struct packed {
      logic busy;
      logic read_issue;
      logic hash_start;
      logic row_we;
      logic sig_we;
      logic load_req;
   } ship_ctrl_type;

endpackage

// ===== rtl/ship_ram.sv =====
// ----------------------------------------------------------------------------
// ship_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ship_ram
   import ship_pkg::*;
#(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic                                 re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/ship_sig_hash.sv =====
// ----------------------------------------------------------------------------
// ship_sig_hash
// Reduces the PC signature field modulo the signature table depth.
// ----------------------------------------------------------------------------
module ship_sig_hash
   import ship_pkg::*;
#(
   parameter int SIG_ENTRIES = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [PC_W-1:0]             pc,
   output logic                        done,
   output logic [$clog2(SIG_ENTRIES)-1:0] sig
);

   localparam int  SIG_W    = $clog2(SIG_ENTRIES);
   localparam bit  SIG_POW2 = (SIG_ENTRIES & (SIG_ENTRIES - 1)) == 0;
   localparam int  SUM_W    = 31;
   localparam int  MUL_W    = 32;
   localparam int  SHIFT    = SUM_W + SIG_W;

   // weight of each chunk of the signature field, 2^(CHUNK_W*j) mod depth
   function automatic logic [CHUNKS*SIG_W-1:0] chunk_weights();
      logic [CHUNKS*SIG_W-1:0] wts;
      longint unsigned         p;
      p = 64'd1;
      for (int j = 0; j < CHUNKS; j++) begin
         wts[j*SIG_W +: SIG_W] = SIG_W'(p);
         p = (p << CHUNK_W) % 64'(SIG_ENTRIES);
      end
      return wts;
   endfunction

   function automatic logic [MUL_W-1:0] reciprocal();
      longint unsigned num;
      num = 64'd1 << SHIFT;
      return MUL_W'((num + 64'(SIG_ENTRIES) - 64'd1) / 64'(SIG_ENTRIES));
   endfunction

   if (SIG_POW2) begin : g_mask
      assign done = start;
      assign sig  = pc[SIG_SHIFT +: SIG_W];
   end else begin : g_fold
      localparam logic [CHUNKS*SIG_W-1:0] WEIGHTS = chunk_weights();
      localparam logic [MUL_W-1:0]        RECIP   = reciprocal();

      logic                   v1_ff, v2_ff, done_ff;
      logic [SUM_W-1:0]       sum, s_ff;
      logic [SUM_W+MUL_W-1:0] prod;
      logic [SIG_W-1:0]       q_ff, r_ff, r_in;

      // fold the chunks with their weights, then divide by the depth with a reciprocal multiply
      always_comb begin
         sum = '0;
         for (int j = 0; j < CHUNKS; j++) begin
            sum = sum + SUM_W'(pc[SIG_SHIFT + j*CHUNK_W +: CHUNK_W])
                      * SUM_W'(WEIGHTS[j*SIG_W +: SIG_W]);
         end
      end

      assign prod = (SUM_W+MUL_W)'(s_ff) * (SUM_W+MUL_W)'(RECIP);
      assign r_in = s_ff[SIG_W-1:0] - q_ff * SIG_W'(SIG_ENTRIES);

      always_ff @(posedge clock) begin
         if (reset) begin
            v1_ff   <= 1'b0;
            v2_ff   <= 1'b0;
            done_ff <= 1'b0;
         end else begin
            v1_ff   <= start;
            v2_ff   <= v1_ff;
            done_ff <= v2_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            s_ff <= sum;
         end
         if (v1_ff) begin
            q_ff <= prod[SHIFT +: SIG_W];
         end
         if (v2_ff) begin
            r_ff <= r_in;
         end
      end

      assign done = done_ff;
      assign sig  = r_ff;
   end

endmodule

// ===== rtl/ship_victim.sv =====
// ----------------------------------------------------------------------------
// ship_victim
// Picks the first way with the largest RRPV and ages the row accordingly.
// ----------------------------------------------------------------------------
module ship_victim
   import ship_pkg::*;
#(
   parameter int NUM_WAYS = 16
) (
   input  logic [NUM_WAYS*RRPV_W-1:0] row,
   output logic [VICTIM_W-1:0]        victim_way,
   output logic [NUM_WAYS*RRPV_W-1:0] aged_row
);

   localparam int WAY_W = $clog2(NUM_WAYS);

   logic [RRPV_W-1:0] top;
   logic [RRPV_W-1:0] age;
   logic [3:0]        has;
   logic [WAY_W-1:0]  best;
   logic              found;

   always_comb begin
      has = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         has[row[w*RRPV_W +: RRPV_W]] = 1'b1;
      end
      if (has[3]) begin
         top = 2'd3;
      end else if (has[2]) begin
         top = 2'd2;
      end else if (has[1]) begin
         top = 2'd1;
      end else begin
         top = 2'd0;
      end
   end

   always_comb begin
      best  = '0;
      found = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!found && row[w*RRPV_W +: RRPV_W] == top) begin
            best  = WAY_W'(w);
            found = 1'b1;
         end
      end
   end

   assign age = RRPV_MAX - top;

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged_row[w*RRPV_W +: RRPV_W] = row[w*RRPV_W +: RRPV_W] + age;
      end
   end

   assign victim_way = VICTIM_W'(best);

endmodule

// ===== rtl/ship_rrip_replacement.sv =====
// ----------------------------------------------------------------------------
// ship_rrip_replacement
// Signature-based RRIP replacement policy with 2-bit RRPVs and counters.
// ----------------------------------------------------------------------------
// A victim request or an update is taken when start is high and busy is low.
// A victim request reads the set row from the RRPV RAM when it is taken; the
// row is aged and written back in the execute state; rsp_valid pulses for one
// cycle, the cycle after that write, with rsp_victim_way, and the receiver
// cannot hold it off. Updates give no response and follow the same path when
// SIG_ENTRIES is a power of two; otherwise the signature is first reduced in
// a multiply pipeline (sum, quotient and remainder registers). CSR writes are
// taken at any time. After reset, busy stays high while both RAMs are cleared
// one entry per cycle, up to the larger of NUM_SETS and SIG_ENTRIES entries.
// ----------------------------------------------------------------------------
module ship_rrip_replacement
   import ship_pkg::*;
#(
   parameter int NUM_SETS    = 2048,
   parameter int NUM_WAYS    = 16,
   parameter int SIG_ENTRIES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [SET_IN_W-1:0]    req_set_index,
   input  logic [WAY_IN_W-1:0]    req_way,
   input  logic [PC_W-1:0]        req_pc,
   input  logic                   req_hit,
   output logic                   rsp_valid,
   output logic [VICTIM_W-1:0]    rsp_victim_way,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SET_W   = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
   localparam int SIG_W   = $clog2(SIG_ENTRIES);
   localparam int ROW_W   = NUM_WAYS * RRPV_W;
   localparam int CLR_LEN = NUM_SETS > SIG_ENTRIES ? NUM_SETS : SIG_ENTRIES;
   localparam int CLR_W   = CLR_LEN > 1 ? $clog2(CLR_LEN) : 1;
   localparam bit SIG_POW2 = (SIG_ENTRIES & (SIG_ENTRIES - 1)) == 0;

   function automatic int set_mod_steps();
      int n;
      n = 0;
      for (int k = 0; k < SET_IN_W; k++) begin
         if ((NUM_SETS << k) < (1 << SET_IN_W)) begin
            n = k + 1;
         end
      end
      return n;
   endfunction

   localparam int SET_STEPS = set_mod_steps();
   localparam logic [ROW_W-1:0] ROW_CLEAR = {NUM_WAYS{RRPV_MAX}};

   ship_state_type state_ff, state_in;
   ship_ctrl_type  ctrl;

   logic [CLR_W-1:0]    clr_ff, clr_in;
   logic                clr_last;
   logic                accept;
   logic [FUNC_W-1:0]   func_ff;
   logic [SET_W-1:0]    set_ff;
   logic [WAY_IN_W-1:0] way_ff;
   logic                hit_ff;
   logic [SIG_W-1:0]    sig_ff;
   logic [RRPV_W-1:0]   insert_ff [NUM_INSERT];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VICTIM_W-1:0] rsp_way_ff;

   logic [SET_IN_W-1:0] set_red;
   logic [SET_W-1:0]    set_mod;
   logic                hash_done;
   logic [SIG_W-1:0]    hash_sig;

   logic [SET_W-1:0]    row_raddr, row_waddr;
   logic [ROW_W-1:0]    row_rdata, row_wdata, row_new, aged_row;
   logic [SIG_W-1:0]    sig_waddr;
   logic [CTR_W-1:0]    sig_rdata, sig_wdata, ctr_new;
   logic [RRPV_W-1:0]   ins_val;
   logic [VICTIM_W-1:0] victim_way;

   assign accept   = start && !busy;
   assign clr_last = clr_ff == CLR_W'(CLR_LEN - 1);

   // reduce the set index modulo the set count
   always_comb begin
      set_red = req_set_index;
      for (int k = SET_STEPS - 1; k >= 0; k--) begin
         if (32'(set_red) >= (NUM_SETS << k)) begin
            set_red = set_red - SET_IN_W'(NUM_SETS << k);
         end
      end
   end

   assign set_mod = SET_W'(set_red);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_VICTIM || SIG_POW2) begin
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.busy   = 1'b1;
            ctrl.row_we = 32'(clr_ff) < NUM_SETS;
            ctrl.sig_we = 32'(clr_ff) < SIG_ENTRIES;
         end
         ST_IDLE: begin
            ctrl.load_req   = start;
            ctrl.hash_start = start && req_func == FUNC_UPDATE;
            ctrl.read_issue = start && (req_func == FUNC_VICTIM || SIG_POW2);
         end
         ST_HASH: begin
            ctrl.busy       = 1'b1;
            ctrl.read_issue = hash_done;
         end
         ST_EXEC: begin
            ctrl.busy   = 1'b1;
            ctrl.row_we = 1'b1;
            ctrl.sig_we = func_ff == FUNC_UPDATE;
         end
         default: begin
            ctrl.busy = 1'b1;
         end
      endcase
   end

   assign busy = ctrl.busy;

   always_comb begin
      clr_in = clr_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request
   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         func_ff <= req_func;
         set_ff  <= set_mod;
         way_ff  <= req_way;
         hit_ff  <= req_hit;
      end
      if (ctrl.read_issue) begin
         sig_ff <= hash_sig;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         insert_ff[CSR_INSERT_DEAD]    <= INSERT_DEAD_RESET;
         insert_ff[CSR_INSERT_MILD]    <= INSERT_MILD_RESET;
         insert_ff[CSR_INSERT_REGULAR] <= INSERT_REGULAR_RESET;
         insert_ff[CSR_INSERT_HOT]     <= INSERT_HOT_RESET;
      end else if (csr_we) begin
         insert_ff[csr_index] <= csr_wdata;
      end
   end

   ship_sig_hash #(
      .SIG_ENTRIES (SIG_ENTRIES)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (ctrl.hash_start),
      .pc    (req_pc),
      .done  (hash_done),
      .sig   (hash_sig)
   );

   assign row_raddr = (state_ff == ST_IDLE) ? set_mod : set_ff;
   assign row_waddr = (state_ff == ST_CLEAR) ? clr_ff[SET_W-1:0] : set_ff;
   assign row_wdata = (state_ff == ST_CLEAR) ? ROW_CLEAR : row_new;
   assign sig_waddr = (state_ff == ST_CLEAR) ? clr_ff[SIG_W-1:0] : sig_ff;
   assign sig_wdata = (state_ff == ST_CLEAR) ? CTR_RESET : ctr_new;

   ship_ram #(
      .DEPTH (NUM_SETS),
      .WIDTH (ROW_W)
   ) u_row_ram (
      .clock (clock),
      .we    (ctrl.row_we),
      .waddr (row_waddr),
      .wdata (row_wdata),
      .re    (ctrl.read_issue),
      .raddr (row_raddr),
      .rdata (row_rdata)
   );

   ship_ram #(
      .DEPTH (SIG_ENTRIES),
      .WIDTH (CTR_W)
   ) u_sig_ram (
      .clock (clock),
      .we    (ctrl.sig_we),
      .waddr (sig_waddr),
      .wdata (sig_wdata),
      .re    (ctrl.read_issue),
      .raddr (hash_sig),
      .rdata (sig_rdata)
   );

   ship_victim #(
      .NUM_WAYS (NUM_WAYS)
   ) u_victim (
      .row        (row_rdata),
      .victim_way (victim_way),
      .aged_row   (aged_row)
   );

   // train the signature counter and pick the new RRPV
   always_comb begin
      if (hit_ff) begin
         ctr_new = (sig_rdata == CTR_MAX) ? CTR_MAX : sig_rdata + 1'b1;
         ins_val = RRPV_HIT;
      end else begin
         ctr_new = (sig_rdata == CTR_MIN) ? CTR_MIN : sig_rdata - 1'b1;
         ins_val = insert_ff[ctr_new];
      end
   end

   always_comb begin
      row_new = aged_row;
      if (func_ff == FUNC_UPDATE) begin
         row_new = row_rdata;
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (32'(way_ff) == w) begin
               row_new[w*RRPV_W +: RRPV_W] = ins_val;
            end
         end
      end
   end

   assign rsp_valid_in = state_ff == ST_EXEC && func_ff == FUNC_VICTIM;

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_way_ff <= victim_way;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_EXEC)
      else $error("response without a preceding execute cycle");

   a_victim_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_VICTIM) |=> ##1 rsp_valid)
      else $error("victim request not answered in two cycles");

   a_hash_done_state: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == ST_HASH || state_ff == ST_IDLE))
      else $error("signature ready outside idle or hash state");

endmodule

// ===== test/ship_rrip_replacement_tb.sv =====
// ----------------------------------------------------------------------------
// ship_rrip_replacement_tb
// Self-checking bench for the signature-based RRIP replacement block.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the field extremes, counter
// saturation at both ends and victim picks with no aging. Random phases
// follow, each with its own insertion setting, over a few hot sets and PCs so
// that rows fill below the top RRPV and victim picks have to age the set. A
// mirror of the RRPV rows, signature counters and insertion registers predicts
// victim ways the table does not give; rsp_valid pulses are checked in order.
// ----------------------------------------------------------------------------
module ship_rrip_replacement_tb;
   import ship_pkg::*;

   localparam int NUM_SETS_TB    = 2048;
   localparam int NUM_WAYS_TB    = 16;
   localparam int SIG_ENTRIES_TB = 4096;
   localparam int SIG_W          = 12;
   localparam int PHASES         = 5;
   localparam int PHASE_REQUESTS = 350;
   localparam int QUIET_TAIL     = 150;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_LIMIT    = 1000;
   localparam int PRINT_LIMIT    = 50;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [SET_IN_W-1:0] set_idx;
      logic [WAY_IN_W-1:0] way;
      logic [PC_W-1:0]     pc;
      logic                hit;
      logic                typed;
      logic [VICTIM_W-1:0] victim;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [FUNC_W-1:0]      req_func;
   logic [SET_IN_W-1:0]    req_set_index;
   logic [WAY_IN_W-1:0]    req_way;
   logic [PC_W-1:0]        req_pc;
   logic                   req_hit;
   logic                   rsp_valid;
   logic [VICTIM_W-1:0]    rsp_victim_way;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic                   typed_expect;
   logic [VICTIM_W-1:0]    typed_victim;

   logic [RRPV_W-1:0]      rrpv_mirror [NUM_SETS_TB*NUM_WAYS_TB];
   logic [CTR_W-1:0]       sig_ctr_mirror [SIG_ENTRIES_TB];
   logic [RRPV_W-1:0]      insert_cfg [NUM_INSERT];
   logic [VICTIM_W-1:0]    pending_victims [$];
   int                     mismatch_count;

   directed_row_type directed_rows [16] = '{
      '{FUNC_VICTIM, 11'd0,    4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 4'd0},
      '{FUNC_VICTIM, 11'd2047, 4'd0,  64'h0,                   1'b0, 1'b1, 4'd0},
      '{FUNC_UPDATE, 11'd0,    4'd0,  64'h0,                   1'b1, 1'b0, 4'd0},
      '{FUNC_UPDATE, 11'd0,    4'd15, 64'h0,                   1'b0, 1'b0, 4'd0},
      '{FUNC_VICTIM, 11'd0,    4'd3,  64'h0,                   1'b0, 1'b1, 4'd1},
      '{FUNC_UPDATE, 11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 4'd0},
      '{FUNC_UPDATE, 11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 4'd0},
      '{FUNC_UPDATE, 11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 4'd0},
      '{FUNC_UPDATE, 11'd2047, 4'd14, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 4'd0},
      '{FUNC_UPDATE, 11'd2047, 4'd13, 64'hFFFF_FFFF_FFFF_000F, 1'b0, 1'b0, 4'd0},
      '{FUNC_UPDATE, 11'd2047, 4'd13, 64'hFFFF_FFFF_FFFF_000F, 1'b0, 1'b0, 4'd0},
      '{FUNC_VICTIM, 11'd2047, 4'd9,  64'hDEAD_BEEF_0000_1234, 1'b1, 1'b1, 4'd0},
      '{FUNC_UPDATE, 11'd2047, 4'd0,  64'h5555_5555_5555_5555, 1'b1, 1'b0, 4'd0},
      '{FUNC_VICTIM, 11'd2047, 4'd0,  64'h0,                   1'b0, 1'b0, 4'd0},
      '{FUNC_UPDATE, 11'h555,  4'hA,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 4'd0},
      '{FUNC_VICTIM, 11'h2AA,  4'd5,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 4'd0}
   };

   ship_rrip_replacement #(
      .NUM_SETS    (NUM_SETS_TB),
      .NUM_WAYS    (NUM_WAYS_TB),
      .SIG_ENTRIES (SIG_ENTRIES_TB)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_set_index  (req_set_index),
      .req_way        (req_way),
      .req_pc         (req_pc),
      .req_hit        (req_hit),
      .rsp_valid      (rsp_valid),
      .rsp_victim_way (rsp_victim_way),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   function automatic logic [VICTIM_W-1:0] choose_victim(input logic [SET_IN_W-1:0] set_idx);
      int                  base;
      logic [RRPV_W-1:0]   top;
      logic [RRPV_W-1:0]   lift;
      logic [VICTIM_W-1:0] pick;
      base = int'(set_idx) * NUM_WAYS_TB;
      top  = rrpv_mirror[base];
      pick = '0;
      for (int w = 1; w < NUM_WAYS_TB; w++) begin
         if (rrpv_mirror[base + w] > top) begin
            top  = rrpv_mirror[base + w];
            pick = w[VICTIM_W-1:0];
         end
      end
      lift = RRPV_MAX - top;
      for (int w = 0; w < NUM_WAYS_TB; w++)
         rrpv_mirror[base + w] = rrpv_mirror[base + w] + lift;
      return pick;
   endfunction

   function automatic void apply_fill(input logic [SET_IN_W-1:0] set_idx,
                                      input logic [WAY_IN_W-1:0] way,
                                      input logic [PC_W-1:0] pc, input logic hit);
      logic [SIG_W-1:0]  sig;
      logic [CTR_W-1:0]  ctr;
      logic [RRPV_W-1:0] fill;
      sig = pc[SIG_SHIFT +: SIG_W];
      ctr = sig_ctr_mirror[sig];
      if (hit) begin
         if (ctr != CTR_MAX) ctr = ctr + 1'b1;
         fill = RRPV_HIT;
      end else begin
         if (ctr != CTR_MIN) ctr = ctr - 1'b1;
         fill = insert_cfg[ctr];
      end
      sig_ctr_mirror[sig] = ctr;
      rrpv_mirror[int'(set_idx) * NUM_WAYS_TB + int'(way)] = fill;
   endfunction

   always @(posedge clock) begin
      logic [VICTIM_W-1:0] want;
      logic [VICTIM_W-1:0] predicted;
      if (reset) begin
         foreach (rrpv_mirror[i]) rrpv_mirror[i] = RRPV_MAX;
         foreach (sig_ctr_mirror[i]) sig_ctr_mirror[i] = CTR_RESET;
         insert_cfg[CSR_INSERT_DEAD]    = INSERT_DEAD_RESET;
         insert_cfg[CSR_INSERT_MILD]    = INSERT_MILD_RESET;
         insert_cfg[CSR_INSERT_REGULAR] = INSERT_REGULAR_RESET;
         insert_cfg[CSR_INSERT_HOT]     = INSERT_HOT_RESET;
         pending_victims.delete();
      end else begin
         if (rsp_valid !== 1'b0) begin
            if (pending_victims.size() == 0) begin
               report_mismatch("victim_way with no request waiting", 64'(rsp_victim_way),
                               64'(0));
            end else begin
               want = pending_victims.pop_front();
               if (rsp_victim_way !== want)
                  report_mismatch("victim_way", 64'(rsp_victim_way), 64'(want));
            end
         end
         if (csr_we)
            insert_cfg[csr_index] = csr_wdata;
         if (start && busy === 1'b0) begin
            if (req_func == FUNC_VICTIM) begin
               predicted = choose_victim(req_set_index);
               pending_victims.push_back(typed_expect ? typed_victim : predicted);
            end else begin
               apply_fill(req_set_index, req_way, req_pc, req_hit);
            end
         end
      end
   end

   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic [SET_IN_W-1:0] set_idx,
                               input logic [WAY_IN_W-1:0] way, input logic [PC_W-1:0] pc,
                               input logic hit, input logic typed,
                               input logic [VICTIM_W-1:0] victim);
      @(negedge clock);
      req_func      = func;
      req_set_index = set_idx;
      req_way       = way;
      req_pc        = pc;
      req_hit       = hit;
      typed_expect  = typed;
      typed_victim  = victim;
      start         = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (busy !== 1'b0 || pending_victims.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_insert(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      logic [SET_IN_W-1:0]   hot_sets [4];
      logic [PC_W-1:0]       hot_pcs [8];
      logic [CSR_DATA_W-1:0] fills [NUM_INSERT];
      logic [SET_IN_W-1:0]   set_idx;
      logic [PC_W-1:0]       pc;
      logic                  quiet;
      int                    waited;
      mismatch_count = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = FUNC_VICTIM;
      req_set_index  = '0;
      req_way        = '0;
      req_pc         = '0;
      req_hit        = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_INSERT_DEAD;
      csr_wdata      = '0;
      typed_expect   = 1'b0;
      typed_victim   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if ($urandom_range(0, 99) < 30) hold_off($urandom_range(1, 10));
         send_request(directed_rows[i].func, directed_rows[i].set_idx, directed_rows[i].way,
                      directed_rows[i].pc, directed_rows[i].hit, directed_rows[i].typed,
                      directed_rows[i].victim);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: fills = '{2'd0, 2'd0, 2'd0, 2'd0};
            1: fills = '{2'd3, 2'd3, 2'd3, 2'd3};
            3: fills = '{INSERT_DEAD_RESET, INSERT_MILD_RESET, INSERT_REGULAR_RESET,
                         INSERT_HOT_RESET};
            default: foreach (fills[i]) fills[i] = CSR_DATA_W'($urandom_range(0, 3));
         endcase
         write_insert(CSR_INSERT_DEAD, fills[0]);
         write_insert(CSR_INSERT_MILD, fills[1]);
         write_insert(CSR_INSERT_REGULAR, fills[2]);
         write_insert(CSR_INSERT_HOT, fills[3]);
         foreach (hot_sets[i]) hot_sets[i] = SET_IN_W'($urandom_range(0, NUM_SETS_TB - 1));
         foreach (hot_pcs[i]) hot_pcs[i] = {$urandom, $urandom};
         quiet = 1'b0;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (phase == PHASES - 1 && n >= PHASE_REQUESTS - QUIET_TAIL) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 99) < 25) hold_off($urandom_range(1, 10));
            if ($urandom_range(0, 99) < 80) set_idx = hot_sets[$urandom_range(0, 3)];
            else set_idx = SET_IN_W'($urandom_range(0, NUM_SETS_TB - 1));
            if ($urandom_range(0, 99) < 75) pc = hot_pcs[$urandom_range(0, 7)];
            else pc = {$urandom, $urandom};
            send_request(($urandom_range(0, 99) < 75) ? FUNC_UPDATE : FUNC_VICTIM, set_idx,
                         WAY_IN_W'($urandom_range(0, NUM_WAYS_TB - 1)), pc,
                         1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end

      @(negedge clock);
      start = 1'b0;
      for (waited = 0; pending_victims.size() != 0 && waited < DRAIN_LIMIT; waited++)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_victims.size() != 0)
         report_mismatch("victim requests left without a result",
                         64'(pending_victims.size()), 64'(0));
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
